// ===== rtl/lzwfd_pkg.sv =====
// Shared types and constants of the fixed-width LZW decoder.
package lzwfd_pkg;

	localparam int CodeBits     = 9;
	localparam int BytesPerWord = 8;
	localparam int WordBits     = 8 * BytesPerWord;
	localparam int DictDepth    = 1 << CodeBits;
	localparam int StackDepth   = 256;

	localparam logic [CodeBits-1:0] END_CODE   = CodeBits'(DictDepth - 1);
	localparam logic [CodeBits-1:0] CLEAR_CODE = CodeBits'(DictDepth - 2);
	localparam logic [CodeBits-1:0] TOP_ENTRY  = CodeBits'(DictDepth - 3);
	localparam logic [CodeBits-1:0] FIRST_FREE = CodeBits'(256);

	localparam logic [7:0] REG_SKIP_COUNT   = 8'd0;
	localparam logic [7:0] REG_OUTPUT_LIMIT = 8'd1;

	typedef struct packed {
		logic                start;
		logic [CodeBits-1:0] code;
	} code_item_t;

	typedef enum logic [1:0] {
		PH_FIRST, PH_RUN, PH_AFTER_CLEAR, PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		B_IDLE, B_WALK, B_WALKD, B_PLAN, B_RD, B_EMIT, B_EMPTY
	} back_state_t;

endpackage

// ===== rtl/lzwfd_front.sv =====
// Front end: packs compressed bytes MSB-first into 9-bit codes.
module lzwfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_start,
	output logic                 push,
	output lzwfd_pkg::code_item_t push_item,
	input  logic                 q_full
);
	import lzwfd_pkg::*;

	logic [15:0] acc_q;
	logic [4:0]  fill_q;
	logic [15:0] acc_n;
	logic [4:0]  fill_n;
	logic [4:0]  fill_r;
	logic        take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign acc_n    = {acc_q[7:0], in_byte};
	assign fill_n   = fill_q + 5'd8;
	assign fill_r   = fill_n - 5'(CodeBits);

	always_comb begin
		push_item.start = in_start;
		push_item.code  = CodeBits'(acc_n >> fill_r);
		push = take && (in_start || (fill_n >= 5'(CodeBits)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (take) begin
			if (in_start) begin
				acc_q  <= {8'd0, in_byte};
				fill_q <= 5'd8;
			end else begin
				acc_q  <= acc_n;
				fill_q <= (fill_n >= 5'(CodeBits)) ? fill_r : fill_n;
			end
		end
	end

endmodule

// ===== rtl/lzwfd_queue.sv =====
// Two-entry queue of codes between front and back end.
module lzwfd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lzwfd_pkg::code_item_t push_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  avail,
	output lzwfd_pkg::code_item_t head
);
	import lzwfd_pkg::*;

	code_item_t slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/lzwfd_back.sv =====
// Back end: dictionary walk, byte emission, skip and limit, result words.
module lzwfd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  lzwfd_pkg::code_item_t head,
	output logic                  pop,
	input  logic [31:0]           skip_count,
	input  logic [31:0]           output_limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           out_word,
	output logic [3:0]            byte_count,
	output logic                  last_of_run,
	output logic                  stream_done,
	output logic                  limit_reached,
	output logic [31:0]           total_out
);
	import lzwfd_pkg::*;

	logic [16:0] dict_mem [DictDepth];
	logic [7:0]  stack_mem [StackDepth];
	logic [16:0] dict_q;
	logic [7:0]  stack_q;

	back_state_t state_q, state_d;
	phase_t      phase_q;
	logic [CodeBits-1:0] next_free_q, prev_q, code_q, c_q;
	logic [7:0]  first_q, lastc_q, rd_q;
	logic [8:0]  n_q, rem_q;
	logic [31:0] skip_left_q, deliv_q;
	logic        lit_q, hit_q;
	logic [WordBits-1:0] word_q;
	logic [3:0]  wcnt_q;

	logic        stack_we;
	logic [7:0]  stack_wa, stack_wd;
	logic        dict_we;

	logic [8:0]  skipn, n_emit, deliver_n, rd_start;
	logic [32:0] sum;
	logic [31:0] room;
	logic        hit;
	logic        out_free, close, walk_more;
	logic [WordBits-1:0] word_n;
	logic [31:0] deliv_n;

	assign out_free  = !out_valid || out_ready;
	assign walk_more = (c_q > CodeBits'(255)) && (n_q < 9'd255);
	assign close     = (wcnt_q == 4'(BytesPerWord - 1)) || (rem_q == 9'd1);
	assign word_n    = word_q | (WordBits'(stack_q) << {wcnt_q[2:0], 3'b000});
	assign deliv_n   = (deliv_q != 32'hFFFF_FFFF) ? deliv_q + 32'd1 : deliv_q;

	assign skipn     = (skip_left_q < {23'd0, n_q}) ? skip_left_q[8:0] : n_q;
	assign n_emit    = n_q - skipn;
	assign sum       = {1'b0, deliv_q} + {24'd0, n_emit};
	assign room      = output_limit - deliv_q;
	assign hit       = (output_limit != 32'd0) && (n_emit != 9'd0)
		&& (sum >= {1'b0, output_limit});
	assign deliver_n = hit ? ((output_limit > deliv_q) ? room[8:0] : 9'd0) : n_emit;
	assign rd_start  = n_q - 9'd1 - skipn;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		stack_we = 1'b0;
		stack_wa = '0;
		stack_wd = '0;
		dict_we  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					if (!head.start && phase_q != PH_DONE) begin
						if (phase_q == PH_FIRST || phase_q == PH_AFTER_CLEAR) begin
							stack_we = 1'b1;
							stack_wd = head.code[7:0];
							state_d  = B_PLAN;
						end else if (head.code == END_CODE) begin
							state_d = B_EMPTY;
						end else if (head.code == CLEAR_CODE) begin
							state_d = B_IDLE;
						end else if (head.code >= next_free_q) begin
							stack_we = 1'b1;
							stack_wd = first_q;
							state_d  = B_WALK;
						end else if (head.code < FIRST_FREE) begin
							stack_we = 1'b1;
							stack_wd = head.code[7:0];
							state_d  = B_PLAN;
						end else begin
							state_d = B_WALK;
						end
					end
				end
			end
			B_WALK: begin
				if (walk_more) begin
					state_d = B_WALKD;
				end else begin
					stack_we = 1'b1;
					stack_wa = n_q[7:0];
					stack_wd = c_q[7:0];
					state_d  = B_PLAN;
				end
			end
			B_WALKD: begin
				stack_we = 1'b1;
				stack_wa = n_q[7:0];
				stack_wd = dict_q[7:0];
				state_d  = B_WALK;
			end
			B_PLAN: begin
				dict_we = !hit && !lit_q && (next_free_q <= TOP_ENTRY);
				if (deliver_n != 9'd0)
					state_d = B_RD;
				else if (hit)
					state_d = B_EMPTY;
				else
					state_d = B_IDLE;
			end
			B_RD: state_d = B_EMIT;
			B_EMIT: begin
				if (!close || out_free)
					state_d = (rem_q == 9'd1) ? B_IDLE : B_RD;
			end
			B_EMPTY: begin
				if (out_free)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (stack_we)
			stack_mem[stack_wa] <= stack_wd;
		stack_q <= stack_mem[rd_q];
		if (dict_we)
			dict_mem[next_free_q] <= {prev_q, lastc_q};
		dict_q <= dict_mem[c_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FIRST;
			next_free_q   <= FIRST_FREE;
			prev_q        <= '0;
			first_q       <= '0;
			skip_left_q   <= '0;
			deliv_q       <= '0;
			out_valid     <= 1'b0;
			code_q        <= '0;
			c_q           <= '0;
			n_q           <= '0;
			lastc_q       <= '0;
			lit_q         <= 1'b0;
			hit_q         <= 1'b0;
			rem_q         <= '0;
			rd_q          <= '0;
			word_q        <= '0;
			wcnt_q        <= '0;
			out_word      <= '0;
			byte_count    <= '0;
			last_of_run   <= 1'b0;
			stream_done   <= 1'b0;
			limit_reached <= 1'b0;
			total_out     <= '0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (avail) begin
						code_q <= head.code;
						lit_q  <= 1'b0;
						hit_q  <= 1'b0;
						if (head.start) begin
							phase_q     <= PH_FIRST;
							next_free_q <= FIRST_FREE;
							prev_q      <= '0;
							first_q     <= '0;
							skip_left_q <= skip_count;
							deliv_q     <= '0;
						end else if (phase_q != PH_DONE) begin
							if (phase_q == PH_FIRST || phase_q == PH_AFTER_CLEAR) begin
								prev_q  <= head.code;
								first_q <= head.code[7:0];
								phase_q <= PH_RUN;
								lit_q   <= 1'b1;
								n_q     <= 9'd1;
								lastc_q <= head.code[7:0];
							end else if (head.code == END_CODE) begin
								phase_q <= PH_DONE;
							end else if (head.code == CLEAR_CODE) begin
								next_free_q <= FIRST_FREE;
								phase_q     <= PH_AFTER_CLEAR;
							end else if (head.code >= next_free_q) begin
								n_q <= 9'd1;
								c_q <= prev_q;
							end else if (head.code < FIRST_FREE) begin
								n_q     <= 9'd1;
								lastc_q <= head.code[7:0];
							end else begin
								n_q <= 9'd0;
								c_q <= head.code;
							end
						end
					end
				end
				B_WALK: begin
					if (!walk_more) begin
						n_q     <= n_q + 9'd1;
						lastc_q <= c_q[7:0];
					end
				end
				B_WALKD: begin
					n_q <= n_q + 9'd1;
					c_q <= dict_q[16:8];
				end
				B_PLAN: begin
					first_q     <= lastc_q;
					hit_q       <= hit;
					skip_left_q <= skip_left_q - {23'd0, skipn};
					rem_q       <= deliver_n;
					rd_q        <= rd_start[7:0];
					word_q      <= '0;
					wcnt_q      <= '0;
					if (hit) begin
						phase_q <= PH_DONE;
					end else if (!lit_q) begin
						prev_q <= code_q;
						if (next_free_q <= TOP_ENTRY)
							next_free_q <= next_free_q + CodeBits'(1);
					end
				end
				B_RD: ;
				B_EMIT: begin
					if (!close || out_free) begin
						deliv_q <= deliv_n;
						rem_q   <= rem_q - 9'd1;
						rd_q    <= rd_q - 8'd1;
						if (close) begin
							out_valid     <= 1'b1;
							out_word      <= word_n;
							byte_count    <= wcnt_q + 4'd1;
							last_of_run   <= rem_q == 9'd1;
							stream_done   <= hit_q;
							limit_reached <= hit_q;
							total_out     <= deliv_n;
							word_q        <= '0;
							wcnt_q        <= '0;
						end else begin
							word_q <= word_n;
							wcnt_q <= wcnt_q + 4'd1;
						end
					end
				end
				B_EMPTY: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						out_word      <= '0;
						byte_count    <= '0;
						last_of_run   <= 1'b1;
						stream_done   <= 1'b1;
						limit_reached <= hit_q;
						total_out     <= deliv_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/lzw_fixed_width_decoder.sv =====
// Top level of the fixed 9-bit LZW decoder.
// One compressed byte is taken per beat; every 9 bits form a code that the back end
// decodes by walking the dictionary chain, one dictionary memory read per chain link,
// then emitting the decoded bytes, one string stack memory read per byte, with a
// planning step per code; the output can hold emission off. A two-entry queue lets
// the input side keep taking bytes while the back end works, until the queue is full.
module lzw_fixed_width_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // in_byte
	input  logic [0:0]   s_tuser,   // start_of_stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // out_word, byte_count, total_out, zero pad
	output logic         m_tlast,
	output logic [1:0]   m_tuser,   // stream_done, limit_reached
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import lzwfd_pkg::*;

	logic [31:0] skip_count_q, output_limit_q;
	logic        push, full, pop, avail;
	code_item_t  push_item, head;
	logic [63:0] out_word;
	logic [3:0]  byte_count;
	logic        stream_done, limit_reached;
	logic [31:0] total_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q   <= '0;
			output_limit_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SKIP_COUNT)
				skip_count_q <= cfg_data;
			else if (cfg_index == REG_OUTPUT_LIMIT)
				output_limit_q <= cfg_data;
		end
	end

	lzwfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_start  (s_tuser[0]),
		.push      (push),
		.push_item (push_item),
		.q_full    (full)
	);

	lzwfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.avail     (avail),
		.head      (head)
	);

	lzwfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.avail         (avail),
		.head          (head),
		.pop           (pop),
		.skip_count    (skip_count_q),
		.output_limit  (output_limit_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_word      (out_word),
		.byte_count    (byte_count),
		.last_of_run   (m_tlast),
		.stream_done   (stream_done),
		.limit_reached (limit_reached),
		.total_out     (total_out)
	);

	assign m_tdata = {4'd0, total_out, byte_count, out_word};
	assign m_tuser = {limit_reached, stream_done};

endmodule

// ===== tb/sv/lzw_decode_checker.sv =====
// Checker that predicts the decoded output words of the LZW decoder and compares every beat.
module lzw_decode_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic         m_tlast,
	input  logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           beats
);
	timeunit 1ns;
	timeprecision 1ps;
	import lzwfd_pkg::*;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        last;
		logic        done;
		logic        lim;
		logic [31:0] total;
	} out_word_t;

	out_word_t expected_words[$];
	out_word_t step_words[$];

	logic [16:0] dict[DictDepth];
	logic [7:0]  char_stack[StackDepth];
	logic [15:0] bit_acc;
	int          bit_fill;
	int          next_free;
	int          prev_code;
	logic [7:0]  first_char;
	phase_t      phase;
	logic [31:0] skip_reg, limit_reg, skip_left, delivered;
	logic        hit_limit;
	logic [63:0] word_acc;
	int          word_cnt;

	task close_word();
		out_word_t r;
		r = '{word: word_acc, cnt: 4'(word_cnt), last: 1'b0, done: 1'b0, lim: 1'b0,
			total: delivered};
		step_words.push_back(r);
		word_acc = '0;
		word_cnt = 0;
	endtask

	task deliver_byte(logic [7:0] b);
		if (phase == PH_DONE) return;
		if (skip_left != 0) begin
			skip_left--;
			return;
		end
		if (limit_reg != 0 && delivered >= limit_reg) begin
			phase = PH_DONE;
			hit_limit = 1'b1;
			return;
		end
		if (step_words.size() >= 64) return;
		word_acc |= 64'(b) << (8 * word_cnt);
		word_cnt++;
		if (delivered != 32'hFFFF_FFFF) delivered++;
		if (word_cnt >= BytesPerWord) close_word();
		if (limit_reg != 0 && delivered >= limit_reg) begin
			phase = PH_DONE;
			hit_limit = 1'b1;
		end
	endtask

	function int unwind_chain(int n, int c);
		logic [16:0] e;
		while (c > 255 && n < StackDepth - 1) begin
			e = dict[c];
			char_stack[n] = e[7:0];
			n++;
			c = int'(e[16:8]);
		end
		char_stack[n] = c[7:0];
		return n + 1;
	endfunction

	task restart_stream();
		bit_acc = '0;
		bit_fill = 0;
		next_free = int'(FIRST_FREE);
		prev_code = 0;
		first_char = '0;
		phase = PH_FIRST;
		skip_left = skip_reg;
		delivered = '0;
	endtask

	task decode_byte(logic [7:0] b, logic st);
		int code, depth;
		logic done_now;
		out_word_t r;
		step_words.delete();
		word_acc = '0;
		word_cnt = 0;
		hit_limit = 1'b0;
		depth = 0;
		if (st) restart_stream();
		if (phase == PH_DONE) return;
		bit_acc = {bit_acc[7:0], b};
		bit_fill += 8;
		if (bit_fill < CodeBits) return;
		bit_fill -= CodeBits;
		code = int'((bit_acc >> bit_fill) & 16'h01FF);
		if (phase == PH_FIRST || phase == PH_AFTER_CLEAR) begin
			prev_code = code;
			first_char = code[7:0];
			phase = PH_RUN;
			deliver_byte(code[7:0]);
		end else if (code == int'(END_CODE)) begin
			phase = PH_DONE;
		end else if (code >= next_free && code == int'(CLEAR_CODE)) begin
			next_free = int'(FIRST_FREE);
			phase = PH_AFTER_CLEAR;
		end else begin
			if (code >= next_free) begin
				char_stack[0] = first_char;
				depth = unwind_chain(1, prev_code);
			end else if (code < 256) begin
				char_stack[0] = code[7:0];
				depth = 1;
			end else begin
				depth = unwind_chain(0, code);
			end
			first_char = char_stack[depth - 1];
			for (int i = depth; i > 0 && phase != PH_DONE; i--)
				deliver_byte(char_stack[i - 1]);
			if (phase != PH_DONE) begin
				if (next_free <= int'(TOP_ENTRY)) begin
					dict[next_free] = {prev_code[8:0], first_char};
					next_free++;
				end
				prev_code = code;
			end
		end
		if (word_cnt > 0 && step_words.size() < 64) close_word();
		done_now = (phase == PH_DONE);
		if (done_now && step_words.size() == 0) close_word();
		foreach (step_words[k]) begin
			r = step_words[k];
			r.last = (k == step_words.size() - 1);
			r.done = done_now;
			r.lim = hit_limit;
			expected_words.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t got, want;
		if (!arst_n) begin
			skip_reg = '0;
			limit_reg = '0;
			restart_stream();
			skip_left = '0;
			expected_words.delete();
			errors = 0;
			beats = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SKIP_COUNT:   skip_reg = cfg_data;
					REG_OUTPUT_LIMIT: limit_reg = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = '{word: m_tdata[63:0], cnt: m_tdata[67:64], last: m_tlast,
					done: m_tuser[0], lim: m_tuser[1], total: m_tdata[99:68]};
				beats++;
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat word=%h cnt=%0d last=%b done=%b lim=%b total=%0d",
						$time, got.word, got.cnt, got.last, got.done, got.lim, got.total);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected word=%h cnt=%0d last=%b done=%b lim=%b total=%0d",
							$time, want.word, want.cnt, want.last, want.done, want.lim, want.total);
						$display("%0t:          actual word=%h cnt=%0d last=%b done=%b lim=%b total=%0d",
							$time, got.word, got.cnt, got.last, got.done, got.lim, got.total);
					end
				end
			end
			if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0]);
			pending = expected_words.size();
		end
	end

endmodule

// ===== tb/sv/lzw_fixed_width_decoder_test.sv =====
// Top of the LZW decoder testbench: clock, reset, register writes, code streams and verdict.
module lzw_fixed_width_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lzwfd_pkg::*;

	localparam int StallLimit = 20000;
	localparam int SettleCycles = 3000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic         m_tlast;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           errors, pending, beats;

	typedef struct {
		logic [7:0] b;
		logic       st;
	} in_beat_t;

	in_beat_t    comp_bytes[$];
	logic [31:0] code_acc;
	int          code_fill;
	int          gen_free;
	bit          gen_literal;
	bit          gen_start;
	int          send_idle_pct, recv_idle_pct;
	int          bytes_sent;
	int          stall_cycles;
	int          hold_left;
	bit          pressured;
	logic [31:0] skip_set[6]  = '{32'd0, 32'd0, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd2};
	logic [31:0] limit_set[6] = '{32'd0, 32'd3, 32'd20, 32'hFFFF_FFFF, 32'd1, 32'd0};

	lzw_fixed_width_decoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lzw_decode_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors), .pending(pending), .beats(beats)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task push_byte(logic [7:0] b);
		in_beat_t x;
		x.b = b;
		x.st = gen_start;
		comp_bytes.push_back(x);
		gen_start = 1'b0;
	endtask

	task put_code(int c);
		code_acc = (code_acc << CodeBits) | 32'(c);
		code_fill += CodeBits;
		while (code_fill >= 8) begin
			push_byte(8'(code_acc >> (code_fill - 8)));
			code_fill -= 8;
		end
		if (c == int'(END_CODE) && !gen_literal) return;
		if (gen_literal) gen_literal = 1'b0;
		else if (c == int'(CLEAR_CODE)) begin
			gen_free = int'(FIRST_FREE);
			gen_literal = 1'b1;
		end else if (gen_free <= int'(TOP_ENTRY)) gen_free++;
	endtask

	task pad_byte();
		if (code_fill > 0) push_byte(8'(code_acc << (8 - code_fill)));
		code_fill = 0;
	endtask

	task open_stream();
		pad_byte();
		gen_start = 1'b1;
		gen_free = int'(FIRST_FREE);
		gen_literal = 1'b1;
	endtask

	task random_stream();
		int n, r;
		open_stream();
		if ($urandom_range(7) == 0) begin
			put_code($urandom_range(256, 511));
			put_code($urandom_range(1) ? int'(END_CODE) : int'(CLEAR_CODE));
			if (gen_literal == 1'b0) return;
		end
		put_code($urandom_range(255));
		n = $urandom_range(2, 12);
		repeat (n) begin
			r = $urandom_range(15);
			if (gen_literal) put_code($urandom_range(255));
			else if (r <= 5) put_code($urandom_range(65, 68));
			else if (r <= 10 && gen_free > 256) put_code($urandom_range(256, gen_free - 1));
			else if (r <= 12 && gen_free <= int'(TOP_ENTRY)) put_code(gen_free);
			else if (r == 13 && gen_free < int'(TOP_ENTRY))
				put_code($urandom_range(gen_free + 1, int'(TOP_ENTRY)));
			else if (r == 14) put_code(int'(CLEAR_CODE));
			else put_code($urandom_range(255));
		end
		if (gen_literal) put_code($urandom_range(255));
		if ($urandom_range(3) != 0) begin
			put_code(int'(END_CODE));
			if ($urandom_range(2) == 0) begin
				pad_byte();
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task write_reg(logic [7:0] idx, logic [31:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task send_byte(in_beat_t x);
		s_tdata <= x.b;
		s_tuser <= x.st;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task drain();
		while (pending != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		code_acc = '0;
		code_fill = 0;
		bytes_sent = 0;
		send_idle_pct = 11;
		recv_idle_pct = 77;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin send_idle_pct = 11; recv_idle_pct = 77; end
				1: begin send_idle_pct = 77; recv_idle_pct = 11; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			write_reg(REG_SKIP_COUNT, skip_set[p]);
			write_reg(REG_OUTPUT_LIMIT, limit_set[p]);
			cfg_valid <= 1'b0;
			comp_bytes.delete();
			case (p)
				0: begin
					open_stream();
					put_code(0);
					put_code(255);
					put_code(257);
					put_code(256);
					put_code(int'(CLEAR_CODE));
					put_code(8'hAA);
					put_code(int'(END_CODE));
					open_stream();
					put_code(511);
					put_code(int'(END_CODE));
					open_stream();
					put_code(1);
					put_code(400);
					put_code(2);
					put_code(int'(END_CODE));
					open_stream();
					put_code(65);
					put_code(66);
					put_code(256);
				end
				1: begin
					put_code(67);
					put_code(257);
					put_code(int'(END_CODE));
				end
				5: begin
					open_stream();
					put_code(120);
					for (int i = 256; i <= 280; i++) put_code(i);
					put_code(int'(END_CODE));
				end
				default: ;
			endcase
			if (p != 0) begin
				while (comp_bytes.size() < 10) random_stream();
				pad_byte();
			end
			foreach (comp_bytes[i]) send_byte(comp_bytes[i]);
			s_tvalid <= 1'b0;
			drain();
		end
		$display("Sent %0d compressed bytes over 6 register settings; checked %0d output beats.",
			bytes_sent, beats);
		$display("Covered literals, KwKwK and stale codes, clears, end codes, skip and limits.");
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		pressured = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!pressured && m_tvalid && m_tready) begin
				pressured = 1'b1;
				hold_left = 600;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		stall_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= StallLimit) begin
				$display("Timeout: no beat moved for %0d cycles", StallLimit);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule
